### rtl/multi_channel_software_timer_core_assert.svh
// assertion macros for the software timer multiplexer
// expects clk and rst_n in the scope of each use
`ifndef MULTI_CHANNEL_SOFTWARE_TIMER_CORE_ASSERT_SVH
`define MULTI_CHANNEL_SOFTWARE_TIMER_CORE_ASSERT_SVH

// same-cycle implication
`define MCST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mcst_pkg.sv
// shared types and constants of the software timer multiplexer
// no dependencies
package mcst_pkg;

    localparam int TIMER_COUNT_DEF = 4;
    localparam int CMD_W = 3;
    localparam int ID_W = 2;
    localparam int TICKS_W = 32;
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_CHARGE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXPIRE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP = 3'd4;

    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_PROG = 1'b1;

    typedef enum logic [2:0] {
        OP_CHARGE,
        OP_ENABLE,
        OP_DISABLE,
        OP_EXPIRE,
        OP_STOP
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    timer_id;
        logic [TICKS_W-1:0] delay_value;
    } cmd_req_t;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    fired_id;
        logic [TICKS_W-1:0] programmed_ticks;
        logic               last;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    timer_id;
        logic [TICKS_W-1:0] delay_value;
    } task_t;

    typedef logic [THR_W-1:0] thr_t;

endpackage

### rtl/mcst_chan_if.sv
// valid/ready channel used for every port of the timer multiplexer
// payload type is given per instance
interface mcst_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/mcst_front.sv
// command front end: decodes requests, drops invalid ones, queues the rest
// depends on mcst_pkg and mcst_chan_if
module mcst_front #(
    parameter int TIMER_COUNT = mcst_pkg::TIMER_COUNT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    mcst_chan_if.sink   req,
    mcst_chan_if.source task_ch
);
    import mcst_pkg::*;

    task_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    op_t               op_dec;
    logic              id_ok;
    logic              keep;
    logic              push;
    logic              pop;

    assign id_ok = int'(req.payload.timer_id) < TIMER_COUNT;

    always_comb
    begin
        op_dec = OP_STOP;
        keep   = 1'b0;
        unique case (req.payload.cmd)
            CMD_CHARGE:
            begin
                op_dec = OP_CHARGE;
                keep   = id_ok;
            end
            CMD_ENABLE:
            begin
                op_dec = OP_ENABLE;
                keep   = id_ok;
            end
            CMD_DISABLE:
            begin
                op_dec = OP_DISABLE;
                keep   = id_ok;
            end
            CMD_EXPIRE:
            begin
                op_dec = OP_EXPIRE;
                keep   = 1'b1;
            end
            CMD_STOP:
            begin
                op_dec = OP_STOP;
                keep   = 1'b1;
            end
            default:
            begin
                op_dec = OP_STOP;
                keep   = 1'b0;
            end
        endcase
    end

    assign req.ready       = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign push            = req.valid && req.ready && keep;
    assign task_ch.valid   = count_reg != '0;
    assign task_ch.payload = queue_reg[rd_ptr_reg];
    assign pop             = task_ch.valid && task_ch.ready;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{op: op_dec, timer_id: req.payload.timer_id,
                                       delay_value: req.payload.delay_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

### rtl/mcst_back.sv
// timer engine: per-slot state, scan sequencer, fire and program results
// depends on mcst_pkg, mcst_chan_if and the assertion macro header
module mcst_back #(
    parameter int TIMER_COUNT = mcst_pkg::TIMER_COUNT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    mcst_chan_if.sink   task_ch,
    mcst_chan_if.sink   cfg,
    mcst_chan_if.source rsp
);
    import mcst_pkg::*;
    `include "multi_channel_software_timer_core_assert.svh"

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIRE = 4'b0100,
        S_PROG = 4'b1000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [IDX_W-1:0]         idx_reg;
    logic                     expire_reg;
    logic [TIMER_COUNT-1:0]   fire_mask_reg;
    logic                     have_min_reg;
    logic [TICKS_W-1:0]       min_reg;
    logic [TIMER_COUNT-1:0]   armed_reg;
    logic [TICKS_W-1:0]       reload_reg [TIMER_COUNT];
    logic [TICKS_W-1:0]       remaining_reg [TIMER_COUNT];
    logic [TICKS_W-1:0]       current_delay_reg;
    logic                     halted_reg;
    thr_t                     thr_reg;
    logic                     rsp_valid_reg;
    result_t                  rsp_data_reg;

    logic                     task_go;
    logic                     start_scan;
    logic [IDX_W-1:0]         slot;
    logic                     idx_last;
    logic [TICKS_W-1:0]       cur_rem;
    logic [TICKS_W-1:0]       sub_rem;
    logic [TICKS_W-1:0]       new_rem;
    logic                     is_fire;
    logic                     min_take;
    logic [TIMER_COUNT-1:0]   mask_upd;
    logic [IDX_W-1:0]         fire_idx;
    logic [TIMER_COUNT-1:0]   fire_rest;
    logic                     can_emit;
    logic                     emit_fire;
    logic                     emit_prog;

    assign cfg.ready     = 1'b1;
    assign task_ch.ready = state_reg == S_IDLE;
    assign task_go       = task_ch.valid && task_ch.ready;
    assign slot          = IDX_W'(task_ch.payload.timer_id);

    always_comb
    begin
        start_scan = 1'b0;
        unique case (task_ch.payload.op) inside
            OP_CHARGE, OP_ENABLE, OP_DISABLE: start_scan = task_go;
            OP_EXPIRE:                        start_scan = task_go && !halted_reg;
            default:                          start_scan = 1'b0;
        endcase
    end

    // scan datapath, one slot per cycle
    assign idx_last = idx_reg == IDX_W'(TIMER_COUNT - 1);
    assign cur_rem  = remaining_reg[idx_reg];
    assign sub_rem  = (current_delay_reg > cur_rem) ? '0 : cur_rem - current_delay_reg;
    assign new_rem  = (expire_reg && armed_reg[idx_reg]) ? sub_rem : cur_rem;
    assign is_fire  = armed_reg[idx_reg] && (new_rem < TICKS_W'(thr_reg));
    assign min_take = armed_reg[idx_reg] && !is_fire && (!have_min_reg || new_rem < min_reg);
    assign mask_upd = fire_mask_reg | (TIMER_COUNT'(is_fire) << idx_reg);

    // lowest pending fire
    always_comb
    begin
        fire_idx = '0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--)
        begin
            if (fire_mask_reg[i])
            begin
                fire_idx = IDX_W'(i);
            end
        end
    end

    assign fire_rest = fire_mask_reg & (fire_mask_reg - TIMER_COUNT'(1));
    assign can_emit  = !rsp_valid_reg || rsp.ready;
    assign emit_fire = (state_reg == S_FIRE) && can_emit;
    assign emit_prog = (state_reg == S_PROG) && can_emit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_last)
                begin
                    if (mask_upd != '0)
                    begin
                        state_next = S_FIRE;
                    end
                    else if (have_min_reg || min_take)
                    begin
                        state_next = S_PROG;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIRE:
            begin
                if (can_emit && fire_rest == '0)
                begin
                    state_next = have_min_reg ? S_PROG : S_IDLE;
                end
            end
            S_PROG:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            expire_reg        <= 1'b0;
            fire_mask_reg     <= '0;
            have_min_reg      <= 1'b0;
            armed_reg         <= '0;
            current_delay_reg <= '0;
            halted_reg        <= 1'b0;
            thr_reg           <= THR_RESET;
            rsp_valid_reg     <= 1'b0;
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                reload_reg[i]    <= '0;
                remaining_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                thr_reg <= cfg.payload;
            end
            if (task_go)
            begin
                case (task_ch.payload.op)
                    OP_CHARGE:
                    begin
                        reload_reg[slot]    <= task_ch.payload.delay_value;
                        remaining_reg[slot] <= task_ch.payload.delay_value;
                        armed_reg[slot]     <= 1'b1;
                    end
                    OP_ENABLE:
                    begin
                        remaining_reg[slot] <= reload_reg[slot];
                        armed_reg[slot]     <= 1'b1;
                    end
                    OP_DISABLE: armed_reg[slot] <= 1'b0;
                    OP_STOP:    halted_reg <= 1'b1;
                    default:    ;
                endcase
                idx_reg       <= '0;
                fire_mask_reg <= '0;
                have_min_reg  <= 1'b0;
                expire_reg    <= task_ch.payload.op == OP_EXPIRE;
            end
            if (state_reg == S_SCAN)
            begin
                remaining_reg[idx_reg] <= new_rem;
                fire_mask_reg          <= mask_upd;
                if (is_fire)
                begin
                    armed_reg[idx_reg] <= 1'b0;
                end
                if (min_take)
                begin
                    have_min_reg <= 1'b1;
                end
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (emit_fire)
            begin
                fire_mask_reg <= fire_rest;
            end
            if (emit_prog)
            begin
                current_delay_reg <= min_reg;
                halted_reg        <= 1'b0;
            end
            if (emit_fire || emit_prog)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && min_take)
        begin
            min_reg <= new_rem;
        end
        if (emit_fire)
        begin
            rsp_data_reg <= '{kind: KIND_FIRE, fired_id: ID_W'(fire_idx),
                              programmed_ticks: '0,
                              last: (fire_rest == '0) && !have_min_reg};
        end
        else if (emit_prog)
        begin
            rsp_data_reg <= '{kind: KIND_PROG, fired_id: '0,
                              programmed_ticks: min_reg, last: 1'b1};
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    `MCST_ASSERT_IMP(a_idle_no_fires, state_reg == S_IDLE, fire_mask_reg == '0, "fires left in idle")
    `MCST_ASSERT_IMP(a_fire_pending, state_reg == S_FIRE, fire_mask_reg != '0, "fire state with no fire")
    `MCST_ASSERT_IMP(a_prog_has_min, state_reg == S_PROG, have_min_reg, "program without armed timer")
    `MCST_ASSERT_NXT(a_prog_unhalts, emit_prog, !halted_reg && rsp_valid_reg, "program did not restart")

endmodule

### rtl/multi_channel_software_timer_core.sv
// top level of the software timer multiplexer: front end, queue, timer engine
// depends on mcst_pkg, mcst_chan_if, mcst_front and mcst_back
//
//  channel | dir | payload                                  | accepted when
//  req     | in  | cmd, timer_id, delay_value               | valid && ready
//  cfg     | in  | fire_threshold (16 bit)                  | valid && ready
//  rsp     | out | kind, fired_id, programmed_ticks, last   | valid && ready
//
// the engine accepts a command in idle, scans every slot, emits one fire result per
// firing timer, then a program result when a delay is programmed; the slot scan reads
// one timer per cycle
// dropped commands take no engine time; stop and halted expire are taken in idle without a scan
// a two-entry queue keeps req open while the engine works or rsp stalls
// reset clears all timers, threshold returns to 64, no clearing pass
module multi_channel_software_timer_core #(
    parameter int TIMER_COUNT = mcst_pkg::TIMER_COUNT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    mcst_chan_if.sink   req,
    mcst_chan_if.sink   cfg,
    mcst_chan_if.source rsp
);
    import mcst_pkg::*;

    mcst_chan_if #(.payload_t(task_t)) task_ch ();

    mcst_front #(
        .TIMER_COUNT(TIMER_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .task_ch (task_ch)
    );

    mcst_back #(
        .TIMER_COUNT(TIMER_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .task_ch (task_ch),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

### bench/multi_channel_software_timer_core_tb.sv
`timescale 1ns / 1ps
// testbench for multi_channel_software_timer_core: directed and random command requests
// with a cycle-free timer predictor, random idling on both sides and threshold changes
// depends on mcst_pkg, mcst_chan_if and the rtl of the timer multiplexer
module multi_channel_software_timer_core_tb;
    import mcst_pkg::*;

    localparam int TMR_SLOTS = TIMER_COUNT_DEF;
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    mcst_chan_if #(.payload_t(cmd_req_t)) req_if ();
    mcst_chan_if #(.payload_t(thr_t))     cfg_if ();
    mcst_chan_if #(.payload_t(result_t))  rsp_if ();

    multi_channel_software_timer_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .cfg   (cfg_if),
        .rsp   (rsp_if)
    );

    // predicted timer state
    bit                 tmr_armed [TMR_SLOTS];
    logic [TICKS_W-1:0] tmr_reload [TMR_SLOTS];
    logic [TICKS_W-1:0] tmr_left [TMR_SLOTS];
    logic [TICKS_W-1:0] prog_delay;
    bit                 halted_q;
    thr_t               threshold_q;

    cmd_req_t cmd_backlog [$];
    result_t  results_due [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cmds_sent = 0;
    int fires_seen = 0;
    int progs_seen = 0;
    int cfg_writes = 0;
    int err_count = 0;

    task automatic report(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // firing pass, then program the smallest remaining time
    function automatic void recalc_outputs();
        result_t            r;
        bit                 have_min;
        logic [TICKS_W-1:0] min_left;
        int                 first;
        first = results_due.size();
        have_min = 1'b0;
        min_left = '1;
        for (int i = 0; i < TMR_SLOTS; i++)
        begin
            if (tmr_armed[i] && tmr_left[i] < {16'd0, threshold_q})
            begin
                tmr_armed[i] = 1'b0;
                r.kind = KIND_FIRE;
                r.fired_id = ID_W'(i);
                r.programmed_ticks = '0;
                r.last = 1'b0;
                results_due.push_back(r);
            end
        end
        for (int i = 0; i < TMR_SLOTS; i++)
        begin
            if (tmr_armed[i] && (!have_min || tmr_left[i] < min_left))
            begin
                min_left = tmr_left[i];
                have_min = 1'b1;
            end
        end
        if (have_min)
        begin
            prog_delay = min_left;
            halted_q = 1'b0;
            r.kind = KIND_PROG;
            r.fired_id = '0;
            r.programmed_ticks = min_left;
            r.last = 1'b0;
            results_due.push_back(r);
        end
        if (results_due.size() > first)
            results_due[results_due.size() - 1].last = 1'b1;
    endfunction

    function automatic void timer_predict(input cmd_req_t c);
        int id;
        id = int'(c.timer_id);
        case (c.cmd) inside
            CMD_CHARGE, CMD_ENABLE, CMD_DISABLE:
            begin
                if (id < TMR_SLOTS)
                begin
                    if (c.cmd == CMD_CHARGE)
                        tmr_reload[id] = c.delay_value;
                    if (c.cmd == CMD_DISABLE)
                        tmr_armed[id] = 1'b0;
                    else
                    begin
                        tmr_armed[id] = 1'b1;
                        tmr_left[id] = tmr_reload[id];
                    end
                    recalc_outputs();
                end
            end
            CMD_EXPIRE:
            begin
                if (!halted_q)
                begin
                    for (int i = 0; i < TMR_SLOTS; i++)
                    begin
                        if (tmr_armed[i])
                            tmr_left[i] = (prog_delay > tmr_left[i]) ? '0
                                                                     : tmr_left[i] - prog_delay;
                    end
                    recalc_outputs();
                end
            end
            CMD_STOP: halted_q = 1'b1;
            default: ;
        endcase
    endfunction

    // request driver
    always @(posedge clk)
    begin : req_driver
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                timer_predict(req_if.payload);
                cmds_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.valid <= 1'b1;
                    req_if.payload <= cmd_backlog.pop_front();
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : rsp_monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (results_due.size() == 0)
                    report($sformatf("unexpected result kind %0d id %0d ticks %h last %0d",
                                     got.kind, got.fired_id, got.programmed_ticks, got.last));
                else
                begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
                        got.programmed_ticks !== want.programmed_ticks ||
                        got.last !== want.last)
                        report($sformatf("got kind %0d id %0d ticks %h last %0d, want %0d %0d %h %0d",
                                         got.kind, got.fired_id, got.programmed_ticks, got.last,
                                         want.kind, want.fired_id, want.programmed_ticks,
                                         want.last));
                    if (want.kind == KIND_FIRE)
                        fires_seen++;
                    else
                        progs_seen++;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int id,
                            input logic [TICKS_W-1:0] delay);
        cmd_req_t c;
        c.cmd = cmd;
        c.timer_id = ID_W'(id);
        c.delay_value = delay;
        cmd_backlog.push_back(c);
    endtask

    task automatic push_random_cmd();
        int                 pick;
        int                 span;
        logic [CMD_W-1:0]   cmd;
        logic [TICKS_W-1:0] delay;
        pick = $urandom_range(99);
        span = int'(threshold_q);
        if (pick < 30)
            cmd = CMD_CHARGE;
        else if (pick < 45)
            cmd = CMD_ENABLE;
        else if (pick < 55)
            cmd = CMD_DISABLE;
        else if (pick < 86)
            cmd = CMD_EXPIRE;
        else if (pick < 93)
            cmd = CMD_STOP;
        else
            cmd = CMD_STOP + CMD_W'($urandom_range(1, 3));
        case ($urandom_range(9)) inside
            0: delay = '0;
            1: delay = '1;
            2, 3: delay = $urandom_range(span * 2 + 4);
            4, 5, 6: delay = span + $urandom_range(4000);
            7: delay = $urandom;
            8: delay = $urandom_range(255);
            default: delay = {24'hFFFFFF, 8'($urandom_range(255))};
        endcase
        push_cmd(cmd, $urandom_range(TMR_SLOTS - 1), delay);
    endtask

    task automatic write_threshold(input thr_t value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        threshold_q = value;
        cfg_writes++;
    endtask

    // sampled at the falling edge so the driver and monitor updates have settled
    task automatic drain();
        while (cmd_backlog.size() != 0 || req_if.valid)
            @(negedge clk);
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input thr_t thr, input int idle_pct, input int stall_pct,
                                    input int count);
        write_threshold(thr);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) push_random_cmd();
        drain();
    endtask

    initial
    begin
        req_if.valid = 1'b0;
        req_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < TMR_SLOTS; i++)
        begin
            tmr_armed[i] = 1'b0;
            tmr_reload[i] = '0;
            tmr_left[i] = '0;
        end
        prog_delay = '0;
        halted_q = 1'b0;
        threshold_q = THR_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // expire with nothing running
        push_cmd(CMD_EXPIRE, 0, 32'd0);
        push_cmd(CMD_CHARGE, 0, 32'd1000);
        push_cmd(CMD_CHARGE, 1, 32'd10);
        push_cmd(CMD_CHARGE, 2, '1);
        push_cmd(CMD_CHARGE, 3, 32'd2000);
        push_cmd(CMD_EXPIRE, 0, 32'd0);
        // expire ignored while halted
        push_cmd(CMD_STOP, 0, 32'd0);
        push_cmd(CMD_EXPIRE, 0, 32'd0);
        push_cmd(CMD_ENABLE, 0, 32'd0);
        push_cmd(CMD_DISABLE, 0, 32'd0);
        push_cmd(CMD_DISABLE, 3, 32'd0);
        push_cmd(CMD_DISABLE, 2, 32'd0);
        push_cmd(CMD_EXPIRE, 0, 32'd0);
        push_cmd(CMD_CHARGE, 0, 32'd0);
        // every timer fires on one expire
        for (int i = 0; i < TMR_SLOTS; i++)
            push_cmd(CMD_CHARGE, i, 32'd100);
        push_cmd(CMD_EXPIRE, 0, 32'd0);
        push_cmd(CMD_ENABLE, 1, 32'd0);
        push_cmd(CMD_CHARGE, 2, 32'd63);
        push_cmd(CMD_CHARGE, 3, 32'd64);
        // unknown commands
        push_cmd(CMD_STOP + 3'd1, 3, '1);
        push_cmd(CMD_STOP + 3'd3, 0, 32'd0);
        push_cmd(CMD_EXPIRE, 0, 32'd0);
        drain();

        run_random_phase(thr_t'(0), 0, 0, 40);
        run_random_phase(thr_t'(16'hFFFF), 80, 0, 40);
        run_random_phase(thr_t'($urandom_range(65535)), 0, 80, 40);
        run_random_phase(thr_t'(300), 36, 36, 40);

        $display("%0d command requests over %0d threshold settings and four idling patterns",
                 cmds_sent, cfg_writes);
        $display("%0d fire and %0d programming results checked", fires_seen, progs_seen);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
